// File: rtl/core/pose_channel_blend_add_assert.svh
// Assertion macros for the channel blend block, included by its top RTL file.
`ifndef POSE_CHANNEL_BLEND_ADD_ASSERT_SVH
`define POSE_CHANNEL_BLEND_ADD_ASSERT_SVH

// Condition must hold in the same cycle as the antecedent.
`define PCBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcba assertion failed");

// Condition must hold in the cycle after the antecedent.
`define PCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcba assertion failed");

// Checked also while reset is asserted.
`define PCBA_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("pcba assertion failed");

`endif

// File: rtl/core/pcba_pkg.sv
package pcba_pkg;

    localparam int unsigned CHANNEL_W = 8;
    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned WEIGHT_W  = 15;
    localparam int unsigned SCALE_W   = 24;
    localparam int unsigned COUNT_W   = 9;

    localparam logic [COUNT_W-1:0]        TRANS_COUNT_RESET = 9'd3;
    localparam logic signed [VALUE_W-1:0] TRANS_MAX         = 16'sd32767;
    // Q14 one: bit 14 of the weight set means one or more
    localparam int unsigned ONE_Q14_BIT = 14;

    typedef enum logic [1:0] {
        CMD_BLEND      = 2'd0,
        CMD_ADD        = 2'd1,
        CMD_ADD_SCALED = 2'd2,
        CMD_COPY       = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                        command;
        logic [CHANNEL_W-1:0]        channel;
        logic signed [VALUE_W-1:0]   value_a;
        logic signed [VALUE_W-1:0]   value_b;
        logic [WEIGHT_W-1:0]         weight;
        logic signed [SCALE_W-1:0]   scale;
    } pcba_item_t;

endpackage

// File: rtl/core/pose_channel_blend_add.sv
// Channel   Direction  Contents
// s_*       in         one channel request: command, channel, a, b, weight, scale
// m_*       out        result value and echoed channel
// cfg_*     in         translation channel count (always ready)
//
// One request per cycle sustained while m_tready holds; m_tvalid is registered.
// Path: input register -> one 17x25 multiplier, add and saturate -> result register.
// Synchronous active-low reset clears both valid flags and restores the count to 3.
// s_tready drops only when the input register is full and the result register is
// held by a stalled m_tready.
module pose_channel_blend_add
    import pcba_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] channel, [23:8] value_a, [39:24] value_b, [54:40] weight,
    // [78:55] scale, [79] zero
    input  logic [79:0]         s_tdata,
    // [1:0] command
    input  logic [1:0]          s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // [15:0] result, [23:16] channel_out
    output logic [23:0]         m_tdata,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data
);

`include "pose_channel_blend_add_assert.svh"

    pcba_item_t                 s_item;
    pcba_item_t                 in_item_reg, in_item_next;
    logic                       in_valid_reg, in_valid_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0]  out_result_reg, out_result_next;
    logic [CHANNEL_W-1:0]       out_channel_reg, out_channel_next;
    logic [COUNT_W-1:0]         trans_count_reg, trans_count_next;
    logic signed [VALUE_W-1:0]  dp_result;
    logic                       out_free;
    logic                       advance;
    logic                       s_accept;

    assign s_item.command = cmd_t'(s_tuser);
    assign s_item.channel = s_tdata[7:0];
    assign s_item.value_a = s_tdata[23:8];
    assign s_item.value_b = s_tdata[39:24];
    assign s_item.weight  = s_tdata[54:40];
    assign s_item.scale   = s_tdata[78:55];

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    pcba_datapath u_datapath (
        .item        (in_item_reg),
        .trans_count (trans_count_reg),
        .result      (dp_result)
    );

    always_comb begin
        in_valid_next    = in_valid_reg;
        in_item_next     = in_item_reg;
        out_valid_next   = out_valid_reg;
        out_result_next  = out_result_reg;
        out_channel_next = out_channel_reg;
        trans_count_next = trans_count_reg;

        if (s_accept) begin
            in_valid_next = 1'b1;
            in_item_next  = s_item;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        if (advance) begin
            out_valid_next   = 1'b1;
            out_result_next  = dp_result;
            out_channel_next = in_item_reg.channel;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            trans_count_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            trans_count_reg <= TRANS_COUNT_RESET;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            trans_count_reg <= trans_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg     <= in_item_next;
        out_result_reg  <= out_result_next;
        out_channel_reg <= out_channel_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_channel_reg, out_result_reg};

    `PCBA_ASSERT_NEXT(a_copy_passes_b, aclk, aresetn,
        advance && in_item_reg.command == CMD_COPY,
        m_tvalid && m_tdata[15:0] == $past(in_item_reg.value_b))
    `PCBA_ASSERT_NOW(a_ready_when_out_empty, aclk, aresetn,
        !out_valid_reg, s_tready)
    `PCBA_ASSERT_ALWAYS(a_reset_clears_out, aclk,
        $past(!aresetn), !m_tvalid)

endmodule

// File: rtl/core/pcba_datapath.sv
module pcba_datapath
    import pcba_pkg::*;
(
    input  pcba_item_t                item,
    input  logic [COUNT_W-1:0]        trans_count,
    output logic signed [VALUE_W-1:0] result
);

    logic                       is_trans;
    logic signed [16:0]         diff_full;
    logic signed [15:0]         diff_wrap;
    logic signed [16:0]         mul_x;
    logic signed [24:0]         mul_y;
    logic signed [41:0]         prod;
    logic signed [17:0]         blend_term;
    logic signed [18:0]         blend_sum;
    logic                       round_up;
    logic signed [25:0]         scaled_q;
    logic signed [26:0]         addend;
    logic signed [26:0]         sum;
    logic signed [15:0]         sum_final;

    assign is_trans  = {1'b0, item.channel} < trans_count;
    assign diff_full = {item.value_b[15], item.value_b} - {item.value_a[15], item.value_a};
    // short-way angle difference
    assign diff_wrap = diff_full[15:0];

    // one shared multiplier: blend uses diff * weight, add-scaled uses b * scale
    always_comb begin
        if (item.command == CMD_ADD_SCALED) begin
            mul_x = {item.value_b[15], item.value_b};
            mul_y = {item.scale[23], item.scale};
        end else begin
            mul_x = is_trans ? diff_full : {diff_wrap[15], diff_wrap};
            mul_y = $signed({10'd0, item.weight});
        end
    end

    assign prod = mul_x * mul_y;

    // a*(1-w) + b*w == a + (b-a)*w, and the floor shift passes through a<<14
    assign blend_term = prod[31:14];
    assign blend_sum  = {{3{item.value_a[15]}}, item.value_a}
                      + {blend_term[17], blend_term};

    // truncate toward zero: bump the floored quotient for negative inexact products
    assign round_up = prod[41] & (|prod[15:0]);
    assign scaled_q = prod[41:16] + {25'd0, round_up};

    assign addend = (item.command == CMD_ADD)
                  ? {{11{item.value_b[15]}}, item.value_b}
                  : {scaled_q[25], scaled_q};
    assign sum    = {{11{item.value_a[15]}}, item.value_a} + addend;

    always_comb begin
        if (!is_trans) begin
            sum_final = sum[15:0];
        end else if (sum > 27'(TRANS_MAX)) begin
            sum_final = TRANS_MAX;
        end else if (sum < -27'(TRANS_MAX)) begin
            sum_final = -TRANS_MAX;
        end else begin
            sum_final = sum[15:0];
        end
    end

    always_comb begin
        unique case (item.command)
            CMD_BLEND: begin
                if (item.weight == '0) begin
                    result = item.value_a;
                end else if (item.weight[ONE_Q14_BIT]) begin
                    result = item.value_b;
                end else begin
                    result = blend_sum[15:0];
                end
            end
            CMD_ADD, CMD_ADD_SCALED: begin
                result = sum_final;
            end
            CMD_COPY: begin
                result = item.value_b;
            end
            default: begin
                result = item.value_a;
            end
        endcase
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import pcba_pkg::*;

    localparam longint ONE_Q14   = 16384;
    localparam longint SAT_LIMIT = 32767;

    typedef struct {
        logic [15:0] result;
        logic [7:0]  channel;
    } channel_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [79:0]         s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data;

    channel_result_t     pending_results[$];
    logic [COUNT_W-1:0]  trans_count;
    int                  mismatch_count;
    bit                  idle_on;

    pose_channel_blend_add dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Expected new channel value for one request under the given translation count.
    function automatic logic [15:0] blend_channel_value(cmd_t cmd, logic [7:0] ch,
                                                       logic signed [15:0] a,
                                                       logic signed [15:0] b,
                                                       logic [14:0] w,
                                                       logic signed [23:0] s,
                                                       logic [COUNT_W-1:0] count);
        longint va, vb, vw, vs, d, v;
        logic signed [15:0] diff;
        bit is_trans;
        va = a;
        vb = b;
        vw = w;
        vs = s;
        is_trans = ({1'b0, ch} < count);
        v = va;
        case (cmd)
            CMD_BLEND: begin
                if (vw == 0) begin
                    v = va;
                end else if (vw >= ONE_Q14) begin
                    v = vb;
                end else if (is_trans) begin
                    v = (va * (ONE_Q14 - vw) + vb * vw) >>> 14;
                end else begin
                    // short-way angle difference, wrapped to 16 bits
                    diff = 16'(vb - va);
                    d = diff;
                    v = va + ((d * vw) >>> 14);
                end
            end
            CMD_ADD, CMD_ADD_SCALED: begin
                if (cmd == CMD_ADD)
                    v = va + vb;
                else
                    v = va + (vb * vs) / 65536; // integer divide truncates toward zero
                if (is_trans) begin
                    if (v > SAT_LIMIT)
                        v = SAT_LIMIT;
                    else if (v < -SAT_LIMIT)
                        v = -SAT_LIMIT;
                end
            end
            default: v = vb;
        endcase
        return v[15:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_value();
        logic [15:0] corners[6];
        corners = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 5)];
        return 16'($urandom);
    endfunction

    function automatic logic [14:0] pick_weight();
        logic [14:0] corners[5];
        corners = '{15'd0, 15'd1, 15'd16383, 15'd16384, 15'd32767};
        case ($urandom_range(0, 3))
            0: return corners[$urandom_range(0, 4)];
            1: return 15'($urandom);
            default: return 15'($urandom_range(0, 16384));
        endcase
    endfunction

    function automatic logic [23:0] pick_scale();
        logic [23:0] corners[5];
        corners = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h010000, 24'hFF0000};
        case ($urandom_range(0, 4))
            0: return corners[$urandom_range(0, 4)];
            1, 2: return 24'($signed($urandom_range(0, 262143)) - 131072);
            default: return 24'($urandom);
        endcase
    endfunction

    // Sink side: random stalls, with idle_on off it stays ready.
    initial begin : result_sink
        int n;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        channel_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: result %0d channel_out %0d",
                       $signed(m_tdata[15:0]), m_tdata[23:16]);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[15:0] !== exp_r.result) begin
                    $error("result: expected %0d, got %0d",
                           $signed(exp_r.result), $signed(m_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_tdata[23:16] !== exp_r.channel) begin
                    $error("channel_out: expected %0d, got %0d",
                           exp_r.channel, m_tdata[23:16]);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_request(input cmd_t cmd, input logic [7:0] ch,
                                input logic [15:0] a, input logic [15:0] b,
                                input logic [14:0] w, input logic [23:0] s);
        int gap;
        channel_result_t exp_r;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, s, w, b, a, ch};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        exp_r.result  = blend_channel_value(cmd, ch, a, b, w, s, trans_count);
        exp_r.channel = ch;
        pending_results.push_back(exp_r);
    endtask

    task automatic send_random_request(input bit near_boundary);
        logic [7:0] ch;
        ch = 8'($urandom);
        if (near_boundary && $urandom_range(0, 1))
            ch = 8'(trans_count - COUNT_W'($urandom_range(0, 1)));
        send_request(cmd_t'($urandom_range(0, 3)), ch, pick_value(), pick_value(),
                     pick_weight(), pick_scale());
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_trans_count(input logic [COUNT_W-1:0] count);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        trans_count = count;
    endtask

    // Runs at the reset count of 3: channels 0..2 translate, 3 and up rotate.
    task automatic test_directed_cases();
        send_request(CMD_BLEND, 8'd0, 16'h8000, 16'h7FFF, 15'd0, 24'd0);
        send_request(CMD_BLEND, 8'd0, 16'h8000, 16'h7FFF, 15'd16384, 24'd0);
        send_request(CMD_BLEND, 8'd1, 16'h8000, 16'h7FFF, 15'd32767, 24'd0);
        send_request(CMD_BLEND, 8'd0, 16'h8000, 16'h7FFF, 15'd1, 24'd0);
        send_request(CMD_BLEND, 8'd2, 16'h8000, 16'h7FFF, 15'd16383, 24'd0);
        // short way crosses the wrap point
        send_request(CMD_BLEND, 8'd200, 16'h7FFF, 16'h8000, 15'd8192, 24'd0);
        send_request(CMD_BLEND, 8'd3, 16'h8000, 16'h7FFF, 15'd16383, 24'd0);
        send_request(CMD_BLEND, 8'd2, 16'hFFFF, 16'h0000, 15'd8192, 24'd0);
        send_request(CMD_BLEND, 8'd3, 16'hFFFF, 16'h0000, 15'd8192, 24'd0);
        send_request(CMD_ADD, 8'd2, 16'h7FFF, 16'h7FFF, 15'd0, 24'd0);
        send_request(CMD_ADD, 8'd0, 16'h8000, 16'h8000, 15'd0, 24'd0);
        send_request(CMD_ADD, 8'd1, 16'h8000, 16'h0000, 15'd0, 24'd0);
        send_request(CMD_ADD, 8'd3, 16'h7FFF, 16'h0001, 15'd0, 24'd0);
        send_request(CMD_ADD, 8'd255, 16'h8000, 16'h8000, 15'd0, 24'd0);
        send_request(CMD_ADD_SCALED, 8'd0, 16'h0000, 16'h7FFF, 15'd0, 24'h7FFFFF);
        send_request(CMD_ADD_SCALED, 8'd0, 16'h0000, 16'h8000, 15'd0, 24'h800000);
        send_request(CMD_ADD_SCALED, 8'd4, 16'd100, 16'hFFFF, 15'd0, 24'd1);
        send_request(CMD_ADD_SCALED, 8'd1, 16'h0000, 16'd3, 15'd0, 24'hFF8000);
        send_request(CMD_ADD_SCALED, 8'd128, 16'h7FFF, 16'h7FFF, 15'd0, 24'h010000);
        send_request(CMD_COPY, 8'd0, 16'h1234, 16'h8000, 15'd32767, 24'h7FFFFF);
        send_request(CMD_COPY, 8'd255, 16'h8000, 16'h7FFF, 15'd0, 24'h800000);
    endtask

    task automatic test_count_sweep();
        logic [COUNT_W-1:0] counts[7];
        counts = '{9'd0, 9'd1, 9'd255, 9'd256, 9'd511, 9'd128, 9'd3};
        foreach (counts[i]) begin
            write_trans_count(counts[i]);
            repeat (30) send_random_request(1'b1);
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            write_trans_count(COUNT_W'($urandom_range(0, 511)));
            idle_on = (phase != 2);
            repeat (200) send_random_request(phase[0]);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        int n;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        trans_count    = TRANS_COUNT_RESET;
        mismatch_count = 0;
        idle_on        = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_count_sweep();
        test_random_traffic();

        s_tvalid <= 1'b0;
        n = 0;
        while (pending_results.size() != 0 && n < 5000) begin
            @(posedge aclk);
            n++;
        end
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pcba_pkg.sv
rtl/core/pcba_datapath.sv
rtl/core/pose_channel_blend_add.sv
sim/tb.sv
